[rtl/sas_pkg.sv]
// shared types, constants and helpers of the sprite animation sequencer
`timescale 1ns / 1ps
package sas_pkg;

    localparam int MAX_FRAMES  = 16;
    localparam int FRAME_W     = 4;
    localparam int CNT_W       = 5;
    localparam int STEP_W      = CNT_W;
    localparam int STEP_DEPTH  = 2 * MAX_FRAMES;
    localparam int DUR_W       = 16;
    localparam int EVT_W       = 4;
    localparam int START_W     = 21;
    localparam int SPEED_SHIFT = 8;
    localparam int CYC_W       = START_W + SPEED_SHIFT;
    localparam int PLAY_W      = 30;
    localparam int TIME_W      = 40;
    localparam int PROD_W      = 32;
    localparam int DIVD_W      = TIME_W - SPEED_SHIFT;
    localparam int FIRE_W      = 6;
    localparam int MAX_FIRED   = 63;
    localparam int CFG_W       = 16;

    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_SETTIME = 2'd2,
        KIND_ADVANCE = 2'd3
    } t_kind;

    localparam logic [1:0] MODE_ONCE = 2'd0;
    localparam logic [1:0] MODE_LOOP = 2'd1;
    localparam logic [1:0] MODE_PING = 2'd2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_FRAMES = 2'd1;
    localparam logic [1:0] CFG_SPEED  = 2'd2;

    typedef struct packed {
        logic accept;
        logic load_wr;
        logic restart_init;
        logic build_step;
        logic do_add;
        logic play_clamp;
        logic mod_start;
        logic play_mod;
        logic srch_rd;
        logic s_inc;
        logic srch_fin;
        logic walk_init;
        logic step_adv;
        logic set_ovf;
        logic latch_fire;
        logic out_event;
        logic out_final;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  once;
        logic  build_last;
        logic  mod_done;
        logic  srch_end;
        logic  srch_hit;
        logic  walk_ok;
        logic  stop_t;
        logic  fire;
        logic  full;
        logic  adv_stop;
        logic  out_free;
    } t_status;

    // steps past the last frame walk back down in ping-pong order
    function automatic logic [FRAME_W-1:0] frame_of_step(input logic [STEP_W-1:0] s,
                                                         input logic [CNT_W-1:0] frames);
        logic [STEP_W:0] refl;
        refl = {frames, 1'b0} - (STEP_W + 1)'(2) - {1'b0, s};
        if (s < frames) begin
            return s[FRAME_W-1:0];
        end
        return refl[FRAME_W-1:0];
    endfunction

endpackage

[rtl/sas_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/sas_mod.sv]
// iterative remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
module sas_mod (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sas_pkg::DIVD_W-1:0] i_dividend,
    input  logic [sas_pkg::START_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [sas_pkg::START_W-1:0] o_rem
);
    import sas_pkg::*;

    localparam int CNT_BITS = $clog2(DIVD_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DIVD_W-1:0]   r_num;
    logic [START_W-1:0]  r_rem;
    logic [START_W-1:0]  r_div;
    logic [START_W:0]    trial;
    logic [START_W:0]    diff;

    always_comb begin
        trial = {r_rem, r_num[DIVD_W-1]};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(DIVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DIVD_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                r_rem <= diff[START_W-1:0];
            end else begin
                r_rem <= trial[START_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

[rtl/sas_ctrl.sv]
// sequencer state machine: decodes transactions and steps the datapath
`timescale 1ns / 1ps
module sas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  sas_pkg::t_status  i_st,
    output sas_pkg::t_cmd     o_cmd
);
    import sas_pkg::*;

    typedef enum logic [12:0] {
        ST_IDLE     = 13'b0000000000001,
        ST_DECODE   = 13'b0000000000010,
        ST_BUILD    = 13'b0000000000100,
        ST_ADD      = 13'b0000000001000,
        ST_REDUCE   = 13'b0000000010000,
        ST_MODW     = 13'b0000000100000,
        ST_SRCH_RD  = 13'b0000001000000,
        ST_SRCH_CMP = 13'b0000010000000,
        ST_SRCH_FIN = 13'b0000100000000,
        ST_WALK_RD  = 13'b0001000000000,
        ST_WALK_CMP = 13'b0010000000000,
        ST_EMIT     = 13'b0100000000000,
        ST_FIN      = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   walk_adv;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        walk_adv = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_st.kind)
                    KIND_LOAD: begin
                        o_cmd.load_wr = 1'b1;
                        n_state       = ST_FIN;
                    end
                    KIND_RESTART: begin
                        o_cmd.restart_init = 1'b1;
                        n_state            = ST_BUILD;
                    end
                    KIND_SETTIME: n_state = ST_REDUCE;
                    KIND_ADVANCE: n_state = ST_ADD;
                    default:      n_state = ST_FIN;
                endcase
            end
            ST_BUILD: begin
                o_cmd.build_step = 1'b1;
                if (i_st.build_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_ADD: begin
                o_cmd.do_add = 1'b1;
                n_state      = ST_REDUCE;
            end
            ST_REDUCE: begin
                if (i_st.once) begin
                    o_cmd.play_clamp = 1'b1;
                    n_state          = ST_SRCH_RD;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    n_state         = ST_MODW;
                end
            end
            ST_MODW: begin
                if (i_st.mod_done) begin
                    o_cmd.play_mod = 1'b1;
                    n_state        = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                o_cmd.srch_rd = 1'b1;
                n_state       = i_st.srch_end ? ST_SRCH_FIN : ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (i_st.srch_hit) begin
                    o_cmd.s_inc = 1'b1;
                    n_state     = ST_SRCH_RD;
                end else begin
                    n_state = ST_SRCH_FIN;
                end
            end
            ST_SRCH_FIN: begin
                o_cmd.srch_fin = 1'b1;
                if (i_st.kind == KIND_ADVANCE && i_st.walk_ok) begin
                    o_cmd.walk_init = 1'b1;
                    n_state         = ST_WALK_RD;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_WALK_RD: n_state = ST_WALK_CMP;
            ST_WALK_CMP: begin
                priority if (i_st.stop_t) begin
                    n_state = ST_FIN;
                end else if (i_st.fire && i_st.full) begin
                    o_cmd.set_ovf = 1'b1;
                    n_state       = ST_FIN;
                end else if (i_st.fire) begin
                    o_cmd.latch_fire = 1'b1;
                    n_state          = ST_EMIT;
                end else begin
                    walk_adv = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.out_event = 1'b1;
                    walk_adv        = 1'b1;
                end
            end
            ST_FIN: begin
                if (i_st.out_free) begin
                    o_cmd.out_final = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // move to the next step, or stop once the walk leaves the interval
        if (walk_adv) begin
            o_cmd.step_adv = 1'b1;
            n_state        = i_st.adv_stop ? ST_FIN : ST_WALK_RD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
endmodule

[rtl/sas_dp.sv]
// datapath: frame tables, step start ram, play position and result register
`timescale 1ns / 1ps
module sas_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [sas_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [1:0]                  i_kind,
    input  logic [3:0]                  i_frame_slot,
    input  logic [15:0]                 i_frame_ticks,
    input  logic [3:0]                  i_frame_events,
    input  logic [39:0]                 i_time_value,
    input  logic [15:0]                 i_tick_count,
    input  logic                        i_out_stall,
    input  sas_pkg::t_cmd               i_cmd,
    output sas_pkg::t_status            o_st,
    output logic                        o_out_valid,
    output logic [3:0]                  o_shown_frame,
    output logic                        o_done_res,
    output logic                        o_event_valid,
    output logic [3:0]                  o_fired_frame,
    output logic [3:0]                  o_fired_events,
    output logic                        o_event_overflow,
    output logic                        o_last
);
    import sas_pkg::*;

    // configuration
    logic [1:0]         r_mode;
    logic [CNT_W-1:0]   r_frames_cfg;
    logic [CFG_W-1:0]   r_speed;
    // frame tables
    logic [DUR_W-1:0]   r_dur [MAX_FRAMES];
    logic [EVT_W-1:0]   r_evt [MAX_FRAMES];
    // captured transaction
    t_kind              r_kind;
    logic [FRAME_W-1:0] r_slot;
    logic [DUR_W-1:0]   r_fticks;
    logic [EVT_W-1:0]   r_fevents;
    logic [TIME_W-1:0]  r_t;
    logic [PROD_W-1:0]  r_prod;
    // play state
    logic [1:0]         r_lat_mode;
    logic [CNT_W-1:0]   r_lat_frames;
    logic [STEP_W-1:0]  r_num_steps;
    logic [START_W-1:0] r_cycle;
    logic [PLAY_W-1:0]  r_play;
    logic               r_started;
    logic [FRAME_W-1:0] r_shown;
    logic               r_done;
    // walk state
    logic [STEP_W-1:0]  r_s;
    logic [START_W-1:0] r_acc;
    logic [PLAY_W-1:0]  r_prev;
    logic               r_incl;
    logic [TIME_W-1:0]  r_cs;
    logic [FIRE_W-1:0]  r_n;
    logic               r_ovf;
    logic [FRAME_W-1:0] r_ff;
    logic [EVT_W-1:0]   r_fe;
    // result register
    logic               r_ov;
    logic [FRAME_W-1:0] r_o_shown;
    logic               r_o_done;
    logic               r_o_ev;
    logic [FRAME_W-1:0] r_o_ff;
    logic [EVT_W-1:0]   r_o_fe;
    logic               r_o_ovf;
    logic               r_o_last;

    logic [START_W-1:0] ram_rd;
    logic [STEP_W-1:0]  ram_raddr;
    logic [START_W-1:0] mod_rem;
    logic               mod_done;

    logic [CYC_W-1:0]   cyc;
    logic [TIME_W-1:0]  cyc40;
    logic               once;
    logic [CNT_W-1:0]   fc_clamp;
    logic [1:0]         mode_lat;
    logic [STEP_W-1:0]  steps_lat;
    logic [FRAME_W-1:0] build_f;
    logic [START_W-1:0] acc_next;
    logic               build_last;
    logic [TIME_W-1:0]  add_sum;
    logic               at_end;
    logic [PLAY_W-9:0]  tick_pos;
    logic               srch_end;
    logic               any_evt;
    logic [TIME_W-1:0]  st_time;
    logic [TIME_W-1:0]  prev40;
    logic [TIME_W-1:0]  cs_next;
    logic [FRAME_W-1:0] cur_f;
    logic [EVT_W-1:0]   cur_m;
    logic               early;
    logic               wrap;
    logic [STEP_W-1:0]  s_next;
    logic [STEP_W-1:0]  end_step;

    always_comb begin
        cyc   = {r_cycle, {SPEED_SHIFT{1'b0}}};
        cyc40 = TIME_W'(cyc);
        once  = (r_lat_mode == MODE_ONCE);

        priority if (r_frames_cfg == '0) begin
            fc_clamp = CNT_W'(1);
        end else if (r_frames_cfg > CNT_W'(MAX_FRAMES)) begin
            fc_clamp = CNT_W'(MAX_FRAMES);
        end else begin
            fc_clamp = r_frames_cfg;
        end
        mode_lat  = (r_mode == MODE_ONCE || r_mode == MODE_PING) ? r_mode : MODE_LOOP;
        steps_lat = (mode_lat == MODE_PING && fc_clamp > CNT_W'(1))
                    ? STEP_W'({fc_clamp, 1'b0} - (CNT_W + 1)'(2)) : fc_clamp;

        build_f    = frame_of_step(r_s, r_lat_frames);
        acc_next   = r_acc + START_W'(r_dur[build_f]);
        s_next     = r_s + STEP_W'(1);
        build_last = (s_next == r_num_steps);

        add_sum = TIME_W'(r_play) + TIME_W'(r_prod);
        if (once && add_sum > cyc40) begin
            add_sum = cyc40;
        end

        at_end   = once && (r_play >= PLAY_W'(cyc));
        tick_pos = r_play[PLAY_W-1:SPEED_SHIFT];
        srch_end = at_end || (s_next >= r_num_steps);
        end_step = at_end ? (r_num_steps - STEP_W'(1)) : r_s;

        any_evt = 1'b0;
        for (int f = 0; f < MAX_FRAMES; f++) begin
            if (CNT_W'(f) < r_lat_frames && r_evt[f] != '0) begin
                any_evt = 1'b1;
            end
        end

        st_time = r_cs + TIME_W'({ram_rd, {SPEED_SHIFT{1'b0}}});
        prev40  = TIME_W'(r_prev);
        early   = (st_time < prev40) || (st_time == prev40 && !r_incl);
        cur_f   = frame_of_step(r_s, r_lat_frames);
        cur_m   = r_evt[cur_f];
        cs_next = r_cs + cyc40;
        wrap    = build_last;

        ram_raddr = i_cmd.srch_rd ? s_next : r_s;

        o_st.kind       = r_kind;
        o_st.once       = once;
        o_st.build_last = build_last;
        o_st.mod_done   = mod_done;
        o_st.srch_end   = srch_end;
        o_st.srch_hit   = ({1'b0, ram_rd} <= tick_pos);
        o_st.walk_ok    = any_evt && !(once && r_prev >= PLAY_W'(cyc));
        o_st.stop_t     = (st_time > r_t);
        o_st.fire       = !early && (cur_m != '0);
        o_st.full       = (r_n >= FIRE_W'(MAX_FIRED));
        o_st.adv_stop   = wrap && (once || cs_next > r_t);
        o_st.out_free   = !r_ov || !i_out_stall;
    end

    sas_ram #(
        .WIDTH (START_W),
        .DEPTH (STEP_DEPTH)
    ) u_step_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.build_step),
        .i_waddr (r_s),
        .i_wdata (r_acc),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rd)
    );

    sas_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_start),
        .i_dividend (r_t[TIME_W-1:SPEED_SHIFT]),
        .i_divisor  (r_cycle),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_LOOP;
            r_frames_cfg <= CNT_W'(1);
            r_speed      <= CFG_W'(256);
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_dur[i] <= DUR_W'(1);
                r_evt[i] <= '0;
            end
            r_lat_mode   <= MODE_LOOP;
            r_lat_frames <= CNT_W'(1);
            r_num_steps  <= STEP_W'(1);
            r_cycle      <= START_W'(1);
            r_play       <= '0;
            r_started    <= 1'b0;
            r_shown      <= '0;
            r_done       <= 1'b0;
            r_ovf        <= 1'b0;
            r_n          <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE:   r_mode       <= i_cfg_data[1:0];
                    CFG_FRAMES: r_frames_cfg <= i_cfg_data[CNT_W-1:0];
                    CFG_SPEED:  r_speed      <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (i_cmd.accept) begin
                r_ovf <= 1'b0;
            end
            if (i_cmd.load_wr) begin
                r_dur[r_slot] <= (r_fticks == '0) ? DUR_W'(1) : r_fticks;
                r_evt[r_slot] <= r_fevents;
            end
            if (i_cmd.restart_init) begin
                r_lat_mode   <= mode_lat;
                r_lat_frames <= fc_clamp;
                r_num_steps  <= steps_lat;
            end
            if (i_cmd.build_step && build_last) begin
                r_cycle   <= acc_next;
                r_play    <= '0;
                r_started <= 1'b0;
                r_shown   <= '0;
                r_done    <= 1'b0;
            end
            if (i_cmd.play_clamp) begin
                r_play    <= (r_t < cyc40) ? r_t[PLAY_W-1:0] : PLAY_W'(cyc);
                r_started <= 1'b1;
            end
            if (i_cmd.mod_start) begin
                r_started <= 1'b1;
            end
            if (i_cmd.play_mod) begin
                r_play <= PLAY_W'({mod_rem, r_t[SPEED_SHIFT-1:0]});
            end
            if (i_cmd.srch_fin) begin
                r_shown <= frame_of_step(end_step, r_lat_frames);
                r_done  <= at_end;
            end
            if (i_cmd.walk_init) begin
                r_n <= '0;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.out_event) begin
                r_n <= r_n + FIRE_W'(1);
            end
            if (i_cmd.out_event || i_cmd.out_final) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // working registers and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind    <= t_kind'(i_kind);
            r_slot    <= i_frame_slot;
            r_fticks  <= i_frame_ticks;
            r_fevents <= i_frame_events;
            r_t       <= i_time_value;
            r_prod    <= PROD_W'({16'b0, i_tick_count} * {16'b0, r_speed});
        end
        if (i_cmd.restart_init) begin
            r_s   <= '0;
            r_acc <= '0;
        end
        if (i_cmd.build_step) begin
            r_s   <= s_next;
            r_acc <= acc_next;
        end
        if (i_cmd.do_add) begin
            r_t    <= add_sum;
            r_prev <= r_play;
            r_incl <= !r_started;
        end
        if (i_cmd.play_clamp || i_cmd.play_mod) begin
            r_s <= '0;
        end
        if (i_cmd.s_inc) begin
            r_s <= s_next;
        end
        if (i_cmd.walk_init) begin
            r_s  <= '0;
            r_cs <= '0;
        end
        if (i_cmd.latch_fire) begin
            r_ff <= cur_f;
            r_fe <= cur_m;
        end
        if (i_cmd.step_adv) begin
            if (wrap) begin
                r_s  <= '0;
                r_cs <= cs_next;
            end else begin
                r_s <= s_next;
            end
        end
        if (i_cmd.out_event) begin
            r_o_shown <= r_shown;
            r_o_done  <= r_done;
            r_o_ev    <= 1'b1;
            r_o_ff    <= r_ff;
            r_o_fe    <= r_fe;
            r_o_ovf   <= 1'b0;
            r_o_last  <= 1'b0;
        end else if (i_cmd.out_final) begin
            r_o_shown <= r_shown;
            r_o_done  <= r_done;
            r_o_ev    <= 1'b0;
            r_o_ff    <= '0;
            r_o_fe    <= '0;
            r_o_ovf   <= r_ovf;
            r_o_last  <= 1'b1;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_shown_frame    = r_o_shown;
    assign o_done_res       = r_o_done;
    assign o_event_valid    = r_o_ev;
    assign o_fired_frame    = r_o_ff;
    assign o_fired_events   = r_o_fe;
    assign o_event_overflow = r_o_ovf;
    assign o_last           = r_o_last;
endmodule

[rtl/sprite_animation_sequencer_core.sv]
// top level of the sprite animation sequencer
//
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_stall | kind, frame_slot, frame_ticks, frame_events,
//          |           |                        | time_value, tick_count
//  out     | output    | o_out_valid / i_out_stall | shown_frame, done_res, event_valid,
//          |           |                        | fired_frame, fired_events, event_overflow, last
//  cfg     | input     | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// load writes one frame table slot; restart builds the step start table, one write per cycle
// set time and advance reduce the time with the bit-serial remainder unit in looping modes,
// then search the play position step by step; advance then walks the steps to emit events
// one transaction is worked on at a time; the final result may wait while the next is taken
// synchronous active-low reset returns tables, play state and handshakes to their idle values
// a stalled result register holds the walk until it drains
`timescale 1ns / 1ps
module sprite_animation_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_frame_slot,
    input  logic [15:0] i_frame_ticks,
    input  logic [3:0]  i_frame_events,
    input  logic [39:0] i_time_value,
    input  logic [15:0] i_tick_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_shown_frame,
    output logic        o_done_res,
    output logic        o_event_valid,
    output logic [3:0]  o_fired_frame,
    output logic [3:0]  o_fired_events,
    output logic        o_event_overflow,
    output logic        o_last
);
    import sas_pkg::*;

    t_cmd    cmd;
    t_status st;

    sas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    sas_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_frame_slot     (i_frame_slot),
        .i_frame_ticks    (i_frame_ticks),
        .i_frame_events   (i_frame_events),
        .i_time_value     (i_time_value),
        .i_tick_count     (i_tick_count),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_st             (st),
        .o_out_valid      (o_out_valid),
        .o_shown_frame    (o_shown_frame),
        .o_done_res       (o_done_res),
        .o_event_valid    (o_event_valid),
        .o_fired_frame    (o_fired_frame),
        .o_fired_events   (o_fired_events),
        .o_event_overflow (o_event_overflow),
        .o_last           (o_last)
    );
endmodule

[rtl/sas_checker.sv]
// port-level checks of the sequencer, bound to the top level
`timescale 1ns / 1ps
module sas_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_shown_frame,
    input logic        o_done_res,
    input logic        o_event_valid,
    input logic [3:0]  o_fired_frame,
    input logic [3:0]  o_fired_events,
    input logic        o_event_overflow,
    input logic        o_last
);
    // a stalled result stays valid and keeps its shown frame, event flag, fired frame, events and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_shown_frame)
            && $stable(o_event_valid) && $stable(o_fired_frame)
            && $stable(o_fired_events) && $stable(o_last))
        else $error("result changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // event results only appear while the transaction is still being worked on
    a_evt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_in_stall)
        else $error("event result pending while input side idle");

    a_evt_xor_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_valid != o_last))
        else $error("result is neither a single event nor the final status");

    a_evt_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_valid |-> (o_fired_events != 4'd0) && !o_event_overflow)
        else $error("event result with empty mask or overflow flag");
endmodule

bind sprite_animation_sequencer_core sas_checker u_sas_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_shown_frame    (o_shown_frame),
    .o_done_res       (o_done_res),
    .o_event_valid    (o_event_valid),
    .o_fired_frame    (o_fired_frame),
    .o_fired_events   (o_fired_events),
    .o_event_overflow (o_event_overflow),
    .o_last           (o_last)
);
